// ----- hdl/gww_pkg.sv -----
// shared types and constants of the greedy word-wrap line splitter
`timescale 1ns / 1ps

package gww_pkg;

	localparam logic [7:0]  CODE_CR    = 8'd13;
	localparam logic [7:0]  CODE_LF    = 8'd10;
	localparam logic [7:0]  CODE_SPACE = 8'd32;
	localparam logic [11:0] WIDTH_MAX  = 12'hFFF;

	localparam int QDEPTH    = 4;
	localparam int QPTR_BITS = $clog2(QDEPTH);
	localparam int QCNT_BITS = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		PAIR_NONE,
		PAIR_LF,
		PAIR_CR
	} pair_t;

	typedef struct packed {
		logic [15:0] offset;
		logic [15:0] length;
		logic        is_last;
	} rec_t;

	typedef struct packed {
		logic [1:0] n;
		rec_t       r0;
		rec_t       r1;
	} push_t;

endpackage

// ----- hdl/gww_front.sv -----
// character classifier and line-state update, emits up to two line records per character
`timescale 1ns / 1ps

module gww_front import gww_pkg::*; #(
	parameter int POS_BITS  = 16,
	parameter int CHAR_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [11:0]          wrap_width,
	input  logic                 take,
	input  logic [CHAR_BITS-1:0] ch,
	input  logic                 last_char,
	output push_t                push
);

	typedef logic [POS_BITS-1:0] pos_t;

	pos_t        pos_q, begin_q, brk_q, fs_q, ls_q, lsb_q, fsa_q;
	logic        fs_none_q, fsa_none_q;
	logic [11:0] wcnt_q;
	pair_t       pend_q;

	pos_t        pos_d, begin_d, brk_d, fs_d, ls_d, lsb_d, fsa_d;
	logic        fs_none_d, fsa_none_d;
	logic [11:0] wcnt_d;
	pair_t       pend_d;

	pos_t        nxt, brk_gap;
	logic [12:0] cnt;
	logic        is_cr, is_lf, solid, swallow, eol, wrap, solid_before;
	logic        a_v, e_v;
	rec_t        rec_a, rec_e;

	function automatic logic [15:0] to16(input pos_t v);
		logic [POS_BITS+15:0] e;
		e = {16'b0, v};
		return e[15:0];
	endfunction

	function automatic rec_t mk(input logic has, input pos_t first, input pos_t last,
			input pos_t lb);
		rec_t r;
		r.is_last = 1'b0;
		if (has) begin
			r.offset = to16(first);
			r.length = to16(pos_t'(last - first + 1'b1));
		end else begin
			r.offset = to16(lb);
			r.length = '0;
		end
		return r;
	endfunction

	function automatic logic [11:0] sat(input pos_t v);
		logic [POS_BITS+11:0] e;
		e = {12'b0, v};
		return (e > {{POS_BITS{1'b0}}, WIDTH_MAX}) ? WIDTH_MAX : e[11:0];
	endfunction

	assign is_cr   = (ch == CHAR_BITS'(CODE_CR));
	assign is_lf   = (ch == CHAR_BITS'(CODE_LF));
	assign solid   = (ch > CHAR_BITS'(CODE_SPACE));
	assign swallow = (pend_q == PAIR_LF && is_lf) || (pend_q == PAIR_CR && is_cr);
	assign eol     = is_cr || is_lf;
	assign nxt     = pos_q + 1'b1;
	assign brk_gap = pos_q - brk_q;
	assign cnt     = {1'b0, wcnt_q} + 13'd1;
	assign wrap    = (cnt > {1'b0, wrap_width}) && (brk_q != begin_q);
	assign solid_before = !fs_none_q && (pos_t'(fs_q - begin_q) < pos_t'(brk_q - begin_q));

	always_comb begin
		pos_d      = nxt;
		begin_d    = begin_q;
		brk_d      = brk_q;
		wcnt_d     = wcnt_q;
		fs_d       = fs_q;
		fs_none_d  = fs_none_q;
		ls_d       = ls_q;
		lsb_d      = lsb_q;
		fsa_d      = fsa_q;
		fsa_none_d = fsa_none_q;
		pend_d     = PAIR_NONE;
		a_v        = 1'b0;
		e_v        = 1'b0;
		rec_a      = '0;
		rec_e      = '0;
		push       = '0;
		if (swallow) begin
			begin_d    = nxt;
			brk_d      = nxt;
			wcnt_d     = '0;
			fs_none_d  = 1'b1;
			fsa_none_d = 1'b1;
		end else if (eol) begin
			a_v        = 1'b1;
			rec_a      = mk(!fs_none_q, fs_q, ls_q, begin_q);
			begin_d    = nxt;
			brk_d      = nxt;
			wcnt_d     = '0;
			fs_none_d  = 1'b1;
			fsa_none_d = 1'b1;
			pend_d     = is_cr ? PAIR_LF : PAIR_CR;
		end else if (wrap) begin
			a_v        = 1'b1;
			rec_a      = mk(solid_before, fs_q, lsb_q, begin_q);
			begin_d    = brk_q + 1'b1;
			brk_d      = brk_q + 1'b1;
			fs_d       = fsa_q;
			fs_none_d  = fsa_none_q;
			wcnt_d     = sat(brk_gap);
			fsa_none_d = 1'b1;
			if (solid) begin
				if (fsa_none_q) begin
					fs_d      = pos_q;
					fs_none_d = 1'b0;
				end
				ls_d = pos_q;
			end
		end else begin
			wcnt_d = cnt[12] ? WIDTH_MAX : cnt[11:0];
			if (!solid) begin
				brk_d      = pos_q;
				lsb_d      = ls_q;
				fsa_none_d = 1'b1;
			end else begin
				if (fs_none_q) begin
					fs_d      = pos_q;
					fs_none_d = 1'b0;
				end
				if (fsa_none_q) begin
					fsa_d      = pos_q;
					fsa_none_d = 1'b0;
				end
				ls_d = pos_q;
			end
		end
		if (last_char) begin
			if (nxt != begin_d) begin
				e_v   = 1'b1;
				rec_e = mk(!fs_none_d, fs_d, ls_d, begin_d);
			end
			if (e_v) begin
				rec_e.is_last = 1'b1;
			end else begin
				rec_a.is_last = a_v;
			end
			pos_d      = '0;
			begin_d    = '0;
			brk_d      = '0;
			wcnt_d     = '0;
			fs_d       = '0;
			fs_none_d  = 1'b1;
			ls_d       = '0;
			lsb_d      = '0;
			fsa_d      = '0;
			fsa_none_d = 1'b1;
			pend_d     = PAIR_NONE;
		end
		if (a_v) begin
			push.r0 = rec_a;
			push.r1 = rec_e;
			push.n  = e_v ? 2'd2 : 2'd1;
		end else begin
			push.r0 = rec_e;
			push.n  = e_v ? 2'd1 : 2'd0;
		end
		if (!take) begin
			push.n = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			begin_q    <= '0;
			brk_q      <= '0;
			wcnt_q     <= '0;
			fs_q       <= '0;
			fs_none_q  <= 1'b1;
			ls_q       <= '0;
			lsb_q      <= '0;
			fsa_q      <= '0;
			fsa_none_q <= 1'b1;
			pend_q     <= PAIR_NONE;
		end else if (take) begin
			pos_q      <= pos_d;
			begin_q    <= begin_d;
			brk_q      <= brk_d;
			wcnt_q     <= wcnt_d;
			fs_q       <= fs_d;
			fs_none_q  <= fs_none_d;
			ls_q       <= ls_d;
			lsb_q      <= lsb_d;
			fsa_q      <= fsa_d;
			fsa_none_q <= fsa_none_d;
			pend_q     <= pend_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take && last_char |=> pos_q == '0 && pend_q == PAIR_NONE && fs_none_q)
		else $error("state not cleared after end of text");
	a_wrap_begin: assert property (@(posedge clk) disable iff (!arst_n)
		take && !last_char && !swallow && !eol && wrap |=>
			begin_q == pos_t'($past(brk_q) + 1'b1))
		else $error("wrapped line does not restart after the break");
	a_solid_seen: assert property (@(posedge clk) disable iff (!arst_n)
		take && !last_char && !swallow && !eol && solid |=> !fs_none_q && ls_q == $past(pos_q))
		else $error("solid character not recorded");
`endif

endmodule

// ----- hdl/gww_queue.sv -----
// short record queue between classifier and output, two writes and one read a cycle
`timescale 1ns / 1ps

module gww_queue import gww_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	input  logic  pop,
	output logic  room,
	output logic  head_valid,
	output rec_t  head
);

	rec_t                 mem_q [QDEPTH];
	logic [QPTR_BITS-1:0] rd_q, wr_q, wr_next;
	logic [QCNT_BITS-1:0] count_q;
	logic                 do_pop;

	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_q];
	assign room       = (count_q <= QCNT_BITS'(QDEPTH - 2));
	assign do_pop     = pop && head_valid;
	assign wr_next    = wr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_next] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q    <= '0;
			wr_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + QPTR_BITS'(push.n);
			rd_q    <= rd_q + QPTR_BITS'(do_pop);
			count_q <= count_q + QCNT_BITS'(push.n) - QCNT_BITS'(do_pop);
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_BITS'(QDEPTH))
		else $error("record queue overflow");
	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop && push.n == 2'd0 |=> count_q == $past(count_q) - 1'b1)
		else $error("record queue count wrong after read");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd0 |-> room)
		else $error("records written without room");
`endif

endmodule

// ----- hdl/greedy_word_wrap_splitter.sv -----
// top level of the greedy word-wrap line splitter
//
// channel   dir  handshake                fields
// in        in   in_valid / in_stall      ch, last_char
// out       out  out_valid / out_stall    line_offset, line_length, is_last
// cfg       in   cfg_valid / cfg_ready    cfg_data (wrap width)
//
// one character per cycle while in_stall is low: the classifier registers the line state per taken character
// a character yields zero to two line records, held in a four-entry record queue
// in_stall rises while fewer than two queue entries are free; records leave one per cycle while out_stall is low
// arst_n clears all line state and sets the wrap width to 80
`timescale 1ns / 1ps

module greedy_word_wrap_splitter import gww_pkg::*; #(
	parameter int POS_BITS  = 16,
	parameter int CHAR_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [CHAR_BITS-1:0] ch,
	input  logic                 last_char,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [15:0]          line_offset,
	output logic [15:0]          line_length,
	output logic                 is_last,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [11:0]          cfg_data
);

	logic [11:0] wrap_width_q;
	logic        take, room;
	push_t       push;
	rec_t        head;

	assign cfg_ready = 1'b1;
	assign in_stall  = !room;
	assign take      = in_valid && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_width_q <= 12'd80;
		end else if (cfg_valid && cfg_ready) begin
			wrap_width_q <= cfg_data;
		end
	end

	gww_front #(
		.POS_BITS  (POS_BITS),
		.CHAR_BITS (CHAR_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.wrap_width (wrap_width_q),
		.take       (take),
		.ch         (ch),
		.last_char  (last_char),
		.push       (push)
	);

	gww_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (!out_stall),
		.room       (room),
		.head_valid (out_valid),
		.head       (head)
	);

	assign line_offset = head.offset;
	assign line_length = head.length;
	assign is_last     = head.is_last;

`ifndef NO_ASSERTIONS
	a_stall_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> push.n == 2'd0)
		else $error("records produced while input stalled");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(line_offset) && $stable(line_length))
		else $error("stalled output transaction changed");
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |=> wrap_width_q == $past(cfg_data))
		else $error("wrap width not written");
`endif

endmodule
